>>> sv/intnp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intnp_pkg
// Types, character codes and helper functions shared by the numeral parser.
// ----------------------------------------------------------------------------
package intnp_pkg;

    localparam int unsigned CH_W    = 8;
    localparam int unsigned ACC_W   = 64;
    localparam int unsigned EXT_W   = ACC_W + 4;   // room for *16 + 15

    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CH_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CH_W-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [CH_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CH_W-1:0] CH_LO_X   = 8'h78;
    localparam logic [CH_W-1:0] CH_UP_X   = 8'h58;
    localparam logic [CH_W-1:0] CH_LO_B   = 8'h62;
    localparam logic [CH_W-1:0] CH_UP_B   = 8'h42;
    localparam logic [CH_W-1:0] DIGIT_NONE = 8'hFF;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_SIGNED = 3'd1,
        PH_ZERO   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_TRAIL  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        RC_DEC = 2'd0,
        RC_HEX = 2'd1,
        RC_BIN = 2'd2,
        RC_OCT = 2'd3
    } t_radix;

    typedef struct packed {
        t_phase             phase;
        logic               negative;
        t_radix             radix;
        logic               no_digits;
        logic [ACC_W-1:0]   accum;
        logic               failed;
    } t_state;

    localparam t_state STATE_RST = '{
        phase:     PH_LEAD,
        negative:  1'b0,
        radix:     RC_DEC,
        no_digits: 1'b1,
        accum:     '0,
        failed:    1'b0
    };

    typedef struct packed {
        logic               hit;    // digit below the base
        logic               ovf;    // accum*base + digit exceeds 64 bits
        logic [ACC_W-1:0]   sum;
    } t_mac;

    typedef struct packed {
        logic               valid;
        logic               ok;
        logic [ACC_W-1:0]   value;
    } t_result;

    function automatic logic is_ws(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [CH_W-1:0] digit_of(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = c - CH_LO_A + 8'd10;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = c - CH_UP_A + 8'd10;
        end
        return d;
    endfunction

    function automatic logic [CH_W-1:0] base_of(input t_radix r);
        logic [CH_W-1:0] b;
        unique case (r)
            RC_DEC:  b = 8'd10;
            RC_HEX:  b = 8'd16;
            RC_BIN:  b = 8'd2;
            RC_OCT:  b = 8'd8;
            default: b = 8'd10;
        endcase
        return b;
    endfunction

endpackage

>>> sv/integer_numeral_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_numeral_parser
// Streams a NUL-terminated integer numeral, one byte per transaction, and
// returns ok plus a 64-bit signed value when the NUL arrives.
// ----------------------------------------------------------------------------
// Takes one character per clock with no gaps while o_stall is low. A character
// is held in an input register, then the step logic (digit decode, shift-add
// multiply by the radix, overflow check) updates the parser state; on NUL the
// result is loaded into the output register and presented from there. The
// per-character state update, the 64-bit multiply-add, is what sets the
// one-character-per-cycle rate. Input is stalled only when a NUL waits in the
// input register while the output register holds a result that is itself
// stalled.
module integer_numeral_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_ok,
    output logic signed [63:0] o_value
);

    logic                         r_in_v;
    logic [intnp_pkg::CH_W-1:0]   r_ch;
    intnp_pkg::t_state            r_st;
    logic                         r_out_v;
    logic                         r_ok;
    logic [intnp_pkg::ACC_W-1:0]  r_value;

    intnp_pkg::t_state            n_st;
    intnp_pkg::t_result           step_res;
    logic                         out_free;
    logic                         consume;
    logic                         in_take;

    intnp_step u_step (
        .i_st  (r_st),
        .i_ch  (r_ch),
        .o_st  (n_st),
        .o_res (step_res)
    );

    assign out_free = !r_out_v || !i_stall;
    assign consume  = r_in_v && (!step_res.valid || out_free);
    assign o_stall  = r_in_v && !consume;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_st    <= intnp_pkg::STATE_RST;
        end else begin
            if (in_take) begin
                r_in_v <= 1'b1;
            end else if (consume) begin
                r_in_v <= 1'b0;
            end
            if (consume) begin
                r_st <= n_st;
            end
            if (out_free) begin
                r_out_v <= consume && step_res.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ch <= i_ch;
        end
        if (out_free && consume && step_res.valid) begin
            r_ok    <= step_res.ok;
            r_value <= step_res.value;
        end
    end

    assign o_valid = r_out_v;
    assign o_ok    = r_ok;
    assign o_value = r_value;

endmodule

>>> sv/intnp_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intnp_mac
// Digit decode plus accum*base + digit by shift-add, with 64-bit overflow flag.
// ----------------------------------------------------------------------------
module intnp_mac (
    input  logic [intnp_pkg::ACC_W-1:0] i_accum,
    input  intnp_pkg::t_radix           i_radix,
    input  logic [intnp_pkg::CH_W-1:0]  i_ch,
    output intnp_pkg::t_mac             o_mac
);

    logic [intnp_pkg::CH_W-1:0]  digit;
    logic [intnp_pkg::EXT_W-1:0] ext;
    logic [intnp_pkg::EXT_W-1:0] scaled;
    logic [intnp_pkg::EXT_W-1:0] total;

    always_comb begin
        digit = intnp_pkg::digit_of(i_ch);
        ext   = {4'b0, i_accum};
        unique case (i_radix)
            intnp_pkg::RC_DEC: scaled = (ext << 3) + (ext << 1);
            intnp_pkg::RC_HEX: scaled = ext << 4;
            intnp_pkg::RC_BIN: scaled = ext << 1;
            intnp_pkg::RC_OCT: scaled = ext << 3;
            default:           scaled = (ext << 3) + (ext << 1);
        endcase
        // only the low nibble matters when the digit is in range
        total     = scaled + {{(intnp_pkg::EXT_W-4){1'b0}}, digit[3:0]};
        o_mac.hit = digit < intnp_pkg::base_of(i_radix);
        o_mac.ovf = |total[intnp_pkg::EXT_W-1:intnp_pkg::ACC_W];
        o_mac.sum = total[intnp_pkg::ACC_W-1:0];
    end

endmodule

>>> sv/intnp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intnp_step
// One character of parsing: next state and, on NUL, the final result.
// ----------------------------------------------------------------------------
module intnp_step (
    input  intnp_pkg::t_state           i_st,
    input  logic [intnp_pkg::CH_W-1:0]  i_ch,
    output intnp_pkg::t_state           o_st,
    output intnp_pkg::t_result          o_res
);

    intnp_pkg::t_radix mac_radix;
    intnp_pkg::t_mac   mac;
    intnp_pkg::t_state dp_in;
    intnp_pkg::t_state dp_out;
    intnp_pkg::t_state fc_out;
    logic              ws;
    logic              ok;
    logic              range_bad;

    // first character of the numeral is always read as decimal
    assign mac_radix = (i_st.phase == intnp_pkg::PH_LEAD || i_st.phase == intnp_pkg::PH_SIGNED)
                       ? intnp_pkg::RC_DEC : i_st.radix;

    intnp_mac u_mac (
        .i_accum (i_st.accum),
        .i_radix (mac_radix),
        .i_ch    (i_ch),
        .o_mac   (mac)
    );

    always_comb begin
        ws = intnp_pkg::is_ws(i_ch);

        // digit handling
        dp_in       = i_st;
        dp_in.phase = intnp_pkg::PH_DIGITS;
        dp_in.radix = mac_radix;
        dp_out      = dp_in;
        if (mac.hit) begin
            if (mac.ovf) begin
                dp_out.failed = 1'b1;
            end else begin
                dp_out.accum     = mac.sum;
                dp_out.no_digits = 1'b0;
            end
        end else if (!dp_in.no_digits && ws) begin
            dp_out.phase = intnp_pkg::PH_TRAIL;
        end else begin
            dp_out.failed = 1'b1;
        end

        // first character after any leading whitespace or sign
        fc_out = dp_out;
        if (i_ch == intnp_pkg::CH_ZERO) begin
            fc_out           = i_st;
            fc_out.radix     = intnp_pkg::RC_OCT;
            fc_out.no_digits = 1'b0;
            fc_out.phase     = intnp_pkg::PH_ZERO;
        end

        // final check; for decimal and octal, exactly 2^63 is allowed only when negative
        ok = !i_st.failed && !i_st.no_digits;
        range_bad = i_st.negative ? (i_st.accum[63] && |i_st.accum[62:0])
                                  : i_st.accum[63];
        if (i_st.radix == intnp_pkg::RC_DEC || i_st.radix == intnp_pkg::RC_OCT) begin
            ok = ok && !range_bad;
        end

        o_st  = i_st;
        o_res = '0;
        if (i_ch == intnp_pkg::CH_NUL) begin
            o_res.valid = 1'b1;
            o_res.ok    = ok;
            o_res.value = !ok ? '0 : (i_st.negative ? (~i_st.accum + 64'd1) : i_st.accum);
            o_st        = intnp_pkg::STATE_RST;
        end else if (!i_st.failed) begin
            unique case (i_st.phase)
                intnp_pkg::PH_LEAD: begin
                    if (ws) begin
                        o_st = i_st;
                    end else if (i_ch == intnp_pkg::CH_MINUS || i_ch == intnp_pkg::CH_PLUS) begin
                        o_st.negative = (i_ch == intnp_pkg::CH_MINUS);
                        o_st.phase    = intnp_pkg::PH_SIGNED;
                    end else begin
                        o_st = fc_out;
                    end
                end
                intnp_pkg::PH_SIGNED: begin
                    o_st = fc_out;
                end
                intnp_pkg::PH_ZERO: begin
                    if (i_ch == intnp_pkg::CH_LO_X || i_ch == intnp_pkg::CH_UP_X) begin
                        o_st.phase     = intnp_pkg::PH_DIGITS;
                        o_st.radix     = intnp_pkg::RC_HEX;
                        o_st.no_digits = 1'b1;
                    end else if (i_ch == intnp_pkg::CH_LO_B || i_ch == intnp_pkg::CH_UP_B) begin
                        o_st.phase     = intnp_pkg::PH_DIGITS;
                        o_st.radix     = intnp_pkg::RC_BIN;
                        o_st.no_digits = 1'b1;
                    end else begin
                        o_st = dp_out;
                    end
                end
                intnp_pkg::PH_DIGITS: begin
                    o_st = dp_out;
                end
                default: begin
                    // trailing whitespace
                    if (!ws) begin
                        o_st.failed = 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

>>> sv/intnp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intnp_checker
// Port-level checks for the numeral parser, bound to the top level.
// ----------------------------------------------------------------------------
module intnp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_ch,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_ok,
    input logic [63:0] o_value
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ok) && $stable(o_value))
        else $error("output transaction changed while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_value == 64'd0)
        else $error("failed numeral with nonzero value");

    // input backpressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !$isunknown(i_ch))
        else $error("input transaction with unknown character");

endmodule

bind integer_numeral_parser intnp_checker u_intnp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_ch    (i_ch),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_ok    (o_ok),
    .o_value (o_value)
);
